FILE: rtl/mlbc_pkg.sv
// Shared types and constants of the markdown line block classifier.
package mlbc_pkg;

	localparam int MAX_BLOCKS_DEF  = 256;
	localparam int OFFSET_BITS_DEF = 16;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [2:0] MAX_HASH = 3'd6;

	localparam logic [1:0] KIND_HEADING   = 2'd0;
	localparam logic [1:0] KIND_PARAGRAPH = 2'd1;
	localparam logic [1:0] KIND_UNORDERED = 2'd2;
	localparam logic [1:0] KIND_ORDERED   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_MANY      = 2'd2;
	localparam logic [1:0] ST_TOO_LONG  = 2'd3;

	typedef enum logic [11:0] {
		PH_START   = 12'b0000_0000_0001,
		PH_HASH    = 12'b0000_0000_0010,
		PH_HASH_SP = 12'b0000_0000_0100,
		PH_HEAD    = 12'b0000_0000_1000,
		PH_UL_MARK = 12'b0000_0001_0000,
		PH_UL_SP   = 12'b0000_0010_0000,
		PH_UL      = 12'b0000_0100_0000,
		PH_DIGITS  = 12'b0000_1000_0000,
		PH_DOT     = 12'b0001_0000_0000,
		PH_OL_SP   = 12'b0010_0000_0000,
		PH_OL      = 12'b0100_0000_0000,
		PH_PARA    = 12'b1000_0000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0]  block_kind;
		logic [2:0]  heading_depth;
		logic [15:0] line_offset;
		logic [15:0] line_length;
		logic [15:0] text_offset;
		logic [15:0] text_length;
		logic        is_summary;
		logic [1:0]  status_code;
		logic [8:0]  block_total;
		logic        last_of_document;
	} res_t;

	// one queue entry: up to two results caused by one input item, first one first
	typedef struct packed {
		logic r0_valid;
		logic r1_valid;
		res_t r0;
		res_t r1;
	} entry_t;

	function automatic res_t summary_res(logic [1:0] status, logic [8:0] total);
		res_t r;
		r                  = '0;
		r.is_summary       = 1'b1;
		r.status_code      = status;
		r.block_total      = total;
		r.last_of_document = 1'b1;
		return r;
	endfunction

endpackage

FILE: rtl/mlbc_front.sv
// Front part: byte intake, line splitting and line classification.
module mlbc_front import mlbc_pkg::*; #(
	parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       q_ready,
	input  logic [7:0] data_byte,
	input  logic       byte_present,
	input  logic       end_of_document,
	output logic       push,
	output entry_t     ev
);

	localparam int OB = OFFSET_BITS;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [OB-1:0] LIMIT = {OB{1'b1}};

	typedef struct packed {
		res_t r;
		logic ovf;
	} close_t;

	logic [OB-1:0] pos_q, lbeg_q, tbeg_q;
	phase_t        phase_q;
	logic [2:0]    hash_q;
	logic          blank_q, cr_q, discard_q;
	logic [CW-1:0] blocks_q;

	logic [OB-1:0] pos_n, lbeg_n, tbeg_n;
	phase_t        phase_n;
	logic [2:0]    hash_n;
	logic          blank_n, cr_n, discard_n;
	logic [CW-1:0] blocks_n;
	entry_t        ev_c;
	close_t        cl_byte, cl_eod;
	logic          accept, digit, term;

	logic [OB-1:0] pos_m, lbeg_m, tbeg_m;
	phase_t        phase_m;
	logic [2:0]    hash_m;
	logic [CW-1:0] blocks_m;

	logic [OB-1:0] mid_tbeg;
	phase_t        mid_phase;
	logic [2:0]    mid_hash;

	logic [OB-1:0] tbeg_n_byte;
	phase_t        phase_n_byte;
	logic [2:0]    hash_n_byte;

	function automatic logic [15:0] to16(logic [OB-1:0] v);
		logic [OB+15:0] w;
		w = {16'b0, v};
		return w[15:0];
	endfunction

	function automatic logic [8:0] to9(logic [CW-1:0] v);
		logic [CW+8:0] w;
		w = {9'b0, v};
		return w[8:0];
	endfunction

	function automatic close_t do_close(phase_t ph, logic [2:0] hr, logic [OB-1:0] lb,
			logic [OB-1:0] tb, logic [OB-1:0] le, logic [CW-1:0] blk);
		close_t        c;
		logic [OB-1:0] co;
		logic [CW-1:0] nb;
		c       = '0;
		co      = lb;
		c.r.block_kind = KIND_PARAGRAPH;
		case (ph)
			PH_HEAD: begin
				c.r.block_kind    = KIND_HEADING;
				c.r.heading_depth = hr;
				co                = tb;
			end
			PH_UL: begin
				c.r.block_kind = KIND_UNORDERED;
				co             = tb;
			end
			PH_OL: begin
				c.r.block_kind = KIND_ORDERED;
				co             = tb;
			end
			default: ;
		endcase
		if (blk >= CW'(MAX_BLOCKS)) begin
			c.r   = summary_res(ST_MANY, to9(blk));
			c.ovf = 1'b1;
		end else begin
			nb                 = blk + 1'b1;
			c.r.line_offset    = to16(lb);
			c.r.line_length    = to16(le - lb);
			c.r.text_offset    = to16(co);
			c.r.text_length    = to16(le - co);
			c.r.block_total    = to9(nb);
		end
		return c;
	endfunction

	assign accept = in_valid && q_ready;
	assign digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign term   = (data_byte == CH_CR) || (data_byte == CH_LF) || (data_byte == CH_NUL);

	assign cl_byte = do_close(phase_q, hash_q, lbeg_q, tbeg_q, pos_q, blocks_q);

	always_comb begin
		pos_n     = pos_q;
		lbeg_n    = lbeg_q;
		tbeg_n    = tbeg_q;
		phase_n   = phase_q;
		hash_n    = hash_q;
		blank_n   = blank_q;
		cr_n      = cr_q;
		blocks_n  = blocks_q;
		discard_n = discard_q;
		ev_c      = '0;

		if (byte_present && !discard_q) begin
			if (pos_q == LIMIT) begin
				ev_c.r0_valid = 1'b1;
				ev_c.r0       = summary_res(ST_TOO_LONG, to9(blocks_q));
				discard_n     = 1'b1;
			end else begin
				pos_n = pos_q + 1'b1;
				cr_n  = 1'b0;
				if ((cr_q && data_byte == CH_LF) || term) begin
					// a terminator, or the LF half of a CRLF
					if (term && !(cr_q && data_byte == CH_LF) && !blank_q) begin
						ev_c.r0_valid = 1'b1;
						ev_c.r0       = cl_byte.r;
						if (cl_byte.ovf)
							discard_n = 1'b1;
						else
							blocks_n = blocks_q + 1'b1;
					end
					if (!(cr_q && data_byte == CH_LF))
						cr_n = (data_byte == CH_CR);
					lbeg_n  = pos_q + 1'b1;
					tbeg_n  = pos_q + 1'b1;
					phase_n = PH_START;
					hash_n  = '0;
					blank_n = 1'b1;
				end else begin
					if (data_byte != CH_SPACE && data_byte != CH_TAB)
						blank_n = 1'b0;
					case (phase_q)
						PH_START: begin
							if (data_byte == CH_HASH) begin
								phase_n = PH_HASH;
								hash_n  = 3'd1;
							end else if (data_byte == CH_MINUS || data_byte == CH_STAR
									|| data_byte == CH_PLUS)
								phase_n = PH_UL_MARK;
							else if (digit)
								phase_n = PH_DIGITS;
							else
								phase_n = PH_PARA;
						end
						PH_HASH: begin
							if (data_byte == CH_HASH && hash_q < MAX_HASH)
								hash_n = hash_q + 1'b1;
							else if (data_byte == CH_SPACE) begin
								phase_n = PH_HASH_SP;
								tbeg_n  = pos_q + 1'b1;
							end else begin
								phase_n = PH_PARA;
								hash_n  = '0;
							end
						end
						PH_HASH_SP: phase_n = PH_HEAD;
						PH_UL_MARK: begin
							if (data_byte == CH_SPACE) begin
								phase_n = PH_UL_SP;
								tbeg_n  = pos_q + 1'b1;
							end else
								phase_n = PH_PARA;
						end
						PH_UL_SP: phase_n = PH_UL;
						PH_DIGITS: begin
							if (data_byte == CH_DOT)
								phase_n = PH_DOT;
							else if (!digit)
								phase_n = PH_PARA;
						end
						PH_DOT: begin
							if (data_byte == CH_SPACE) begin
								phase_n = PH_OL_SP;
								tbeg_n  = pos_q + 1'b1;
							end else
								phase_n = PH_PARA;
						end
						PH_OL_SP: phase_n = PH_OL;
						default: ;
					endcase
				end
			end
		end

		if (end_of_document) begin
			if (!discard_n) begin
				// an open line is closed by the end of the document
				if (!blank_n) begin
					ev_c.r0_valid = 1'b1;
					ev_c.r0       = cl_eod.r;
					if (cl_eod.ovf)
						discard_n = 1'b1;
					else
						blocks_n = blocks_n + 1'b1;
				end
				if (!discard_n) begin
					ev_c.r1_valid = 1'b1;
					ev_c.r1 = summary_res((blocks_n == '0) ? ST_EMPTY : ST_OK, to9(blocks_n));
				end
			end
			pos_n     = '0;
			lbeg_n    = '0;
			tbeg_n    = '0;
			phase_n   = PH_START;
			hash_n    = '0;
			blank_n   = 1'b1;
			cr_n      = 1'b0;
			blocks_n  = '0;
			discard_n = 1'b0;
		end
	end

	// close at end of document sees the state left by this item's byte
	always_comb begin
		pos_m    = pos_q;
		lbeg_m   = lbeg_q;
		tbeg_m   = tbeg_q;
		phase_m  = phase_q;
		hash_m   = hash_q;
		blocks_m = blocks_q;
		if (byte_present && !discard_q && pos_q != LIMIT) begin
			pos_m = pos_q + 1'b1;
			if (!term && !(cr_q && data_byte == CH_LF)) begin
				tbeg_m  = mid_tbeg;
				phase_m = mid_phase;
				hash_m  = mid_hash;
			end
		end
	end

	// the line state after a non-terminator byte is exactly what the byte path computes
	assign mid_tbeg  = tbeg_n_byte;
	assign mid_phase = phase_n_byte;
	assign mid_hash  = hash_n_byte;

	always_comb begin
		tbeg_n_byte  = tbeg_q;
		phase_n_byte = phase_q;
		hash_n_byte  = hash_q;
		case (phase_q)
			PH_START: begin
				if (data_byte == CH_HASH) begin
					phase_n_byte = PH_HASH;
					hash_n_byte  = 3'd1;
				end else if (data_byte == CH_MINUS || data_byte == CH_STAR
						|| data_byte == CH_PLUS)
					phase_n_byte = PH_UL_MARK;
				else if (digit)
					phase_n_byte = PH_DIGITS;
				else
					phase_n_byte = PH_PARA;
			end
			PH_HASH: begin
				if (data_byte == CH_HASH && hash_q < MAX_HASH)
					hash_n_byte = hash_q + 1'b1;
				else if (data_byte == CH_SPACE) begin
					phase_n_byte = PH_HASH_SP;
					tbeg_n_byte  = pos_q + 1'b1;
				end else begin
					phase_n_byte = PH_PARA;
					hash_n_byte  = '0;
				end
			end
			PH_HASH_SP: phase_n_byte = PH_HEAD;
			PH_UL_MARK: begin
				if (data_byte == CH_SPACE) begin
					phase_n_byte = PH_UL_SP;
					tbeg_n_byte  = pos_q + 1'b1;
				end else
					phase_n_byte = PH_PARA;
			end
			PH_UL_SP: phase_n_byte = PH_UL;
			PH_DIGITS: begin
				if (data_byte == CH_DOT)
					phase_n_byte = PH_DOT;
				else if (!digit)
					phase_n_byte = PH_PARA;
			end
			PH_DOT: begin
				if (data_byte == CH_SPACE) begin
					phase_n_byte = PH_OL_SP;
					tbeg_n_byte  = pos_q + 1'b1;
				end else
					phase_n_byte = PH_PARA;
			end
			PH_OL_SP: phase_n_byte = PH_OL;
			default: ;
		endcase
	end

	// a byte that closed a line leaves it blank, so only the line begin matters there
	assign cl_eod = do_close(phase_m, hash_m, lbeg_m, tbeg_m, pos_m, blocks_m);

	assign push = accept && (ev_c.r0_valid || ev_c.r1_valid);
	assign ev   = ev_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			lbeg_q    <= '0;
			tbeg_q    <= '0;
			phase_q   <= PH_START;
			hash_q    <= '0;
			blank_q   <= 1'b1;
			cr_q      <= 1'b0;
			blocks_q  <= '0;
			discard_q <= 1'b0;
		end else if (accept) begin
			pos_q     <= pos_n;
			lbeg_q    <= lbeg_n;
			tbeg_q    <= tbeg_n;
			phase_q   <= phase_n;
			hash_q    <= hash_n;
			blank_q   <= blank_n;
			cr_q      <= cr_n;
			blocks_q  <= blocks_n;
			discard_q <= discard_n;
		end
	end

endmodule

FILE: rtl/mlbc_queue.sv
// Short register queue between the classifier front and the output back.
module mlbc_queue import mlbc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t din,
	output logic   ready,
	input  logic   pop,
	output logic   valid,
	output entry_t dout
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	entry_t        mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign ready   = (cnt_q != CW'(QUEUE_DEPTH));
	assign valid   = (cnt_q != '0);
	assign dout    = mem_q[rd_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: rtl/mlbc_back.sv
// Back part: expands queue entries into single results behind an output register.
module mlbc_back import mlbc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	input  entry_t q_entry,
	output logic   q_pop,
	output logic   out_valid,
	input  logic   out_ready,
	output res_t   out_res
);

	logic out_valid_q, sub_q;
	res_t out_res_q;
	logic free, sel_first, load;
	res_t nxt;

	assign free      = !out_valid_q || out_ready;
	assign sel_first = q_entry.r0_valid && !sub_q;
	assign load      = free && q_valid;
	// an entry with two results stays at the head until its second one is taken
	assign q_pop     = load && !(sel_first && q_entry.r1_valid);
	assign nxt       = sel_first ? q_entry.r0 : q_entry.r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 1'b0;
		end else if (free) begin
			out_valid_q <= q_valid;
			if (q_valid)
				sub_q <= sel_first && q_entry.r1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_res_q <= nxt;
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

FILE: rtl/markdown_line_block_classifier.sv
// Top level of the markdown line block classifier.
// One document byte is taken per cycle while the queue has room (tuser marks a present
// byte, tlast closes the document). Each non-blank line gives one descriptor when its
// terminator arrives; the end of a document gives a summary, so an item may cause two
// results, which leave one after the other, first one first. Intake and output are
// parted by a four-entry queue of per-item result records and an output register, so
// the input side keeps taking one byte per cycle while results wait, and stalls only
// when the queue is full. Results pass through the queue and then the output register.
module markdown_line_block_classifier import mlbc_pkg::*; #(
	parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tuser,  // byte_present
	input  logic        s_axis_tlast,  // end_of_document
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// block_kind, heading_depth, line_offset, line_length, text_offset,
	// text_length, status_code, block_total
	output logic [79:0] m_axis_tdata,
	output logic        m_axis_tuser,  // is_summary
	output logic        m_axis_tlast   // last_of_document
);

	logic   q_ready, push, q_valid, q_pop;
	entry_t ev, q_entry;
	res_t   res;

	mlbc_front #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.q_ready        (q_ready),
		.data_byte      (s_axis_tdata),
		.byte_present   (s_axis_tuser),
		.end_of_document(s_axis_tlast),
		.push           (push),
		.ev             (ev)
	);

	mlbc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (ev),
		.ready (q_ready),
		.pop   (q_pop),
		.valid (q_valid),
		.dout  (q_entry)
	);

	mlbc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (res)
	);

	assign s_axis_tready = q_ready;
	assign m_axis_tdata  = {res.block_total, res.status_code, res.text_length,
		res.text_offset, res.line_length, res.line_offset, res.heading_depth,
		res.block_kind};
	assign m_axis_tuser  = res.is_summary;
	assign m_axis_tlast  = res.last_of_document;

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the markdown line block classifier.
`timescale 1ns / 100ps

module tb;
	import mlbc_pkg::*;

	typedef logic [7:0] octet_t;
	typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	localparam int unsigned POS_LIMIT = (1 << OFFSET_BITS_DEF) - 1;

	// Predicts descriptors and summaries from accepted bytes and checks them in order.
	class line_scoreboard;
		res_t pending_results[$];
		int errors;
		int unsigned pos;
		int unsigned line_begin;
		int unsigned text_begin;
		phase_t phase;
		bit [2:0] hashes;
		bit blank;
		bit cr_seen;
		int unsigned blocks;
		bit dropping;

		function new();
			errors = 0;
			restart_doc();
		endfunction

		function void restart_doc();
			pos = 0;
			blocks = 0;
			dropping = 1'b0;
			cr_seen = 1'b0;
			open_line(0);
		endfunction

		function void open_line(int unsigned at);
			line_begin = at;
			text_begin = at;
			phase = PH_START;
			hashes = 3'd0;
			blank = 1'b1;
		endfunction

		function void add_summary(logic [1:0] status);
			res_t r;
			r = '0;
			r.is_summary = 1'b1;
			r.status_code = status;
			r.block_total = 9'(blocks);
			r.last_of_document = 1'b1;
			pending_results.push_back(r);
		endfunction

		function void close_line(int unsigned line_stop);
			res_t r;
			int unsigned coff;
			if (blank)
				return;
			r = '0;
			r.block_kind = KIND_PARAGRAPH;
			coff = line_begin;
			case (phase)
				PH_HEAD: begin
					r.block_kind = KIND_HEADING;
					r.heading_depth = hashes;
					coff = text_begin;
				end
				PH_UL: begin
					r.block_kind = KIND_UNORDERED;
					coff = text_begin;
				end
				PH_OL: begin
					r.block_kind = KIND_ORDERED;
					coff = text_begin;
				end
				default: ;
			endcase
			if (blocks >= MAX_BLOCKS_DEF) begin
				add_summary(ST_MANY);
				dropping = 1'b1;
				return;
			end
			blocks++;
			r.line_offset = 16'(line_begin);
			r.line_length = 16'(line_stop - line_begin);
			r.text_offset = 16'(coff);
			r.text_length = 16'(line_stop - coff);
			r.block_total = 9'(blocks);
			pending_results.push_back(r);
		endfunction

		function void classify(octet_t b, int unsigned at);
			bit digit;
			digit = (b >= CH_ZERO && b <= CH_NINE);
			if (b != CH_SPACE && b != CH_TAB)
				blank = 1'b0;
			case (phase)
				PH_START: begin
					if (b == CH_HASH) begin
						phase = PH_HASH;
						hashes = 3'd1;
					end else if (b == CH_MINUS || b == CH_STAR || b == CH_PLUS)
						phase = PH_UL_MARK;
					else if (digit)
						phase = PH_DIGITS;
					else
						phase = PH_PARA;
				end
				PH_HASH: begin
					if (b == CH_HASH && hashes < MAX_HASH)
						hashes++;
					else if (b == CH_SPACE) begin
						phase = PH_HASH_SP;
						text_begin = at + 1;
					end else begin
						phase = PH_PARA;
						hashes = 3'd0;
					end
				end
				PH_HASH_SP: phase = PH_HEAD;
				PH_UL_MARK: begin
					if (b == CH_SPACE) begin
						phase = PH_UL_SP;
						text_begin = at + 1;
					end else
						phase = PH_PARA;
				end
				PH_UL_SP: phase = PH_UL;
				PH_DIGITS: begin
					if (b == CH_DOT)
						phase = PH_DOT;
					else if (!digit)
						phase = PH_PARA;
				end
				PH_DOT: begin
					if (b == CH_SPACE) begin
						phase = PH_OL_SP;
						text_begin = at + 1;
					end else
						phase = PH_PARA;
				end
				PH_OL_SP: phase = PH_OL;
				default: ;
			endcase
		endfunction

		function void take_item(octet_t b, logic present, logic eod);
			int unsigned at;
			if (present && !dropping) begin
				at = pos;
				if (at >= POS_LIMIT) begin
					add_summary(ST_TOO_LONG);
					dropping = 1'b1;
				end else begin
					pos = at + 1;
					if (cr_seen && b == CH_LF) begin
						// second half of CRLF
						cr_seen = 1'b0;
						open_line(at + 1);
					end else begin
						cr_seen = 1'b0;
						if (b == CH_CR || b == CH_LF || b == CH_NUL) begin
							close_line(at);
							open_line(at + 1);
							cr_seen = (b == CH_CR);
						end else
							classify(b, at);
					end
				end
			end
			if (eod) begin
				if (!dropping) begin
					close_line(pos);
					if (!dropping)
						add_summary(blocks == 0 ? ST_EMPTY : ST_OK);
				end
				restart_doc();
			end
		endfunction

		function bit differs(string field, int unsigned want, int unsigned got);
			if (want == got)
				return 1'b0;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			return 1'b1;
		endfunction

		function void check_result(res_t got);
			res_t want;
			bit bad;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			bad = 1'b0;
			bad |= differs("block_kind", want.block_kind, got.block_kind);
			bad |= differs("heading_depth", want.heading_depth, got.heading_depth);
			bad |= differs("line_offset", want.line_offset, got.line_offset);
			bad |= differs("line_length", want.line_length, got.line_length);
			bad |= differs("text_offset", want.text_offset, got.text_offset);
			bad |= differs("text_length", want.text_length, got.text_length);
			bad |= differs("is_summary", want.is_summary, got.is_summary);
			bad |= differs("status_code", want.status_code, got.status_code);
			bad |= differs("block_total", want.block_total, got.block_total);
			bad |= differs("last_of_document", want.last_of_document, got.last_of_document);
			if (bad)
				errors++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	line_scoreboard sb;
	int burst_left;
	bit steady;
	int hold_left;
	int random_sent;

	markdown_line_block_classifier DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	initial begin
		#10ms;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: switches between stall patterns, plus one long hold-off on request
	initial begin
		rx_mode_t mode;
		int span;
		int tick;
		m_axis_tready = 1'b0;
		mode = RX_STEADY;
		span = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (span == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					span = $urandom_range(20, 200);
				end
				span--;
				tick++;
				case (mode)
					RX_STEADY: m_axis_tready <= 1'b1;
					RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_axis_tready <= (tick % 4 == 0);
					default:   m_axis_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.block_kind = m_axis_tdata[1:0];
			got.heading_depth = m_axis_tdata[4:2];
			got.line_offset = m_axis_tdata[20:5];
			got.line_length = m_axis_tdata[36:21];
			got.text_offset = m_axis_tdata[52:37];
			got.text_length = m_axis_tdata[68:53];
			got.status_code = m_axis_tdata[70:69];
			got.block_total = m_axis_tdata[79:71];
			got.is_summary = m_axis_tuser;
			got.last_of_document = m_axis_tlast;
			sb.check_result(got);
		end
	end

	task automatic send_item(input octet_t b, input logic present, input logic eod);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= present;
		s_axis_tlast <= eod;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.take_item(b, present, eod);
	endtask

	// bare marks a document closed by an item without a byte
	task automatic send_doc(input octet_t doc[$], input bit bare, input bit noisy);
		int n;
		n = doc.size();
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 29) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(doc[i], 1'b1, (i == n - 1) && !bare);
		end
		if (bare || n == 0)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void add_text(ref octet_t q[$], input string s);
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
	endfunction

	function automatic octet_t text_char();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 8'($urandom_range(128, 255));
		if (pick == 1)
			return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
		return 8'($urandom_range(33, 126));
	endfunction

	function automatic void add_line(ref octet_t q[$], input bit term);
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			repeat ($urandom_range(1, 7)) q.push_back(CH_HASH);
			if ($urandom_range(0, 6) != 0)
				q.push_back(CH_SPACE);
		end else if (pick < 36) begin
			case ($urandom_range(0, 2))
				0: q.push_back(CH_MINUS);
				1: q.push_back(CH_STAR);
				default: q.push_back(CH_PLUS);
			endcase
			if ($urandom_range(0, 6) != 0)
				q.push_back(CH_SPACE);
		end else if (pick < 54) begin
			repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
			if ($urandom_range(0, 9) != 0)
				q.push_back(CH_DOT);
			if ($urandom_range(0, 6) != 0)
				q.push_back(CH_SPACE);
		end
		if (pick < 70) begin
			n = (pick < 54) ? $urandom_range(0, 8) : $urandom_range(1, 10);
			repeat (n) q.push_back(text_char());
		end else if (pick < 80) begin
			// whitespace-only line
			repeat ($urandom_range(0, 4)) q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
		end else begin
			repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
		end
		if (!term)
			return;
		case ($urandom_range(0, 5))
			0: q.push_back(CH_CR);
			1: begin
				q.push_back(CH_CR);
				q.push_back(CH_LF);
			end
			2: q.push_back(CH_NUL);
			3: begin
				q.push_back(CH_LF);
				q.push_back(CH_CR);
			end
			default: q.push_back(CH_LF);
		endcase
	endfunction

	task automatic send_block_run(input int lines, input bit tail);
		octet_t doc[$];
		repeat (lines) begin
			doc.push_back(8'($urandom_range(33, 126)));
			doc.push_back(CH_LF);
		end
		if (tail)
			doc.push_back(8'($urandom_range(33, 126)));
		send_doc(doc, !tail, 1'b0);
	endtask

	initial begin
		octet_t doc[$];
		int nlines;
		bit bare;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		burst_left = 0;
		steady = 1'b0;
		hold_left = 0;
		random_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// deepest heading with CRLF, list item, ordered item closed by end of document
		add_text(doc, "###### h");
		doc.push_back(CH_CR);
		doc.push_back(CH_LF);
		add_text(doc, "- u");
		doc.push_back(CH_LF);
		add_text(doc, "12. x");
		send_doc(doc, 1'b0, 1'b0);
		// end marker alone: empty document
		doc.delete();
		send_doc(doc, 1'b1, 1'b0);
		// seven hashes fall back to paragraph, NUL terminates
		add_text(doc, "####### z");
		doc.push_back(CH_NUL);
		send_doc(doc, 1'b1, 1'b0);
		// blank line only
		doc.delete();
		doc.push_back(CH_SPACE);
		doc.push_back(CH_TAB);
		doc.push_back(CH_LF);
		send_doc(doc, 1'b0, 1'b0);
		wait_drain();

		// output held off while input keeps streaming: queue fills, input stalls
		steady = 1'b1;
		hold_left = 300;
		send_block_run(30, 1'b0);
		steady = 1'b0;
		wait_drain();

		while (random_sent < 280) begin
			doc.delete();
			nlines = $urandom_range(0, 10);
			for (int i = 0; i < nlines; i++)
				add_line(doc, (i != nlines - 1) || $urandom_range(0, 2) != 0);
			bare = (doc.size() == 0) || ($urandom_range(0, 3) == 0);
			send_doc(doc, bare, 1'b1);
			random_sent += doc.size() + bare;
		end
		wait_drain();

		// block count limit: the line after the last allowed block overflows, the rest is dropped
		send_block_run(MAX_BLOCKS_DEF + 1, 1'b1);
		// fresh document after the dropped one
		doc.delete();
		add_text(doc, "+ ok");
		send_doc(doc, 1'b0, 1'b0);
		wait_drain();
		repeat (20) @(posedge clk);

		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
